### design/xcbs_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte step for the XMODEM-CRC block sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package xcbs_pkg;

  // Frame geometry
  localparam int BLOCK_BYTES = 128;
  localparam int HDR_BYTES   = 3;
  localparam int FRAME_LEN   = BLOCK_BYTES + HDR_BYTES + 2;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_START = 8'h43;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Request codes on the input tuser
  localparam logic [2:0] REQ_PAYLOAD = 3'd0;
  localparam logic [2:0] REQ_RX      = 3'd1;
  localparam logic [2:0] REQ_SLOT    = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  // Configuration register indexes and port widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT      = 2'd1;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST      = 16'd1000;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;

  // Front-to-back queue depth default
  localparam int QUEUE_DEPTH_DEF = 2;

  // Classified item kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD,
    KIND_RX,
    KIND_SLOT,
    KIND_TICK,
    KIND_RESTART,
    KIND_NONE
  } kind_t;

  // One classified item as it sits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;   // payload byte or received byte
    logic       last;   // final payload byte of the transfer
  } item_t;

  // CRC-16/XMODEM update by one byte, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/xmodem_crc_block_sender.sv
// Path: an accepted item passes through the front queue, then the result register, before its result is presented.
// Throughput: one item per cycle while the output is not stalled (m_tready); the back end handles one item per
//   cycle and the front queue (two entries by default) keeps accepting while a finished result waits on the output.
// Reset (rst, synchronous): sequencer in start wait, block number 1, counters cleared,
//   max_attempts 10, response timeout 1000 ticks; the block buffer is not cleared.
`default_nettype none

module xmodem_crc_block_sender
  import xcbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] payload_byte, [15:8] rx_byte
  input  logic [S_TUSER_W-1:0]   s_tuser,   // [2:0] req_type
  input  logic                   s_tlast,   // payload_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] tx_byte, [8] payload_accepted, [11:9] phase, [19:12] attempts_used,
  // [27:20] block_number, [31:28] zero
  output logic [M_TDATA_W-1:0]   m_tdata,
  output logic                   m_tuser,   // tx_valid
  output logic                   m_tlast,   // frame_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  logic [7:0]  max_attempts;
  logic [15:0] timeout_ticks;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts  <= MAX_ATTEMPTS_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_ATTEMPTS: max_attempts  <= cfg_data[7:0];
        CFG_TIMEOUT:      timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  xcbs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  xcbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .max_attempts (max_attempts),
    .timeout_ticks(timeout_ticks),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

`default_nettype wire

### design/xcbs_front.sv
// Front end: decodes incoming stream beats into items and queues them for the back end.
// Depends on xcbs_pkg.
`default_nettype none

module xcbs_front
  import xcbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] payload_byte, [15:8] rx_byte
  input  logic [S_TUSER_W-1:0] s_tuser,   // [2:0] req_type
  input  logic                 s_tlast,   // payload_last
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            new_item;
  logic             push;

  // Classify the beat
  always_comb begin
    new_item.last = s_tlast;
    new_item.data = s_tdata[15:8];
    unique case (s_tuser)
      REQ_PAYLOAD: begin
        new_item.kind = KIND_PAYLOAD;
        new_item.data = s_tdata[7:0];
      end
      REQ_RX:      new_item.kind = KIND_RX;
      REQ_SLOT:    new_item.kind = KIND_SLOT;
      REQ_TICK:    new_item.kind = KIND_TICK;
      REQ_RESTART: new_item.kind = KIND_RESTART;
      default:     new_item.kind = KIND_NONE;
    endcase
  end

  assign s_tready = (count != CNT_FULL);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue fill level out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1)
    else $error("queue did not grow on push");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### design/xcbs_back.sv
// Back end: transfer sequencer, block buffer, CRC and the result register.
// Depends on xcbs_pkg; takes items from xcbs_front.
`default_nettype none

module xcbs_back
  import xcbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_pop,
  input  logic [7:0]           max_attempts,
  input  logic [15:0]          timeout_ticks,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  typedef enum logic [2:0] {
    PH_WAIT_START   = 3'd0,
    PH_FILL         = 3'd1,
    PH_SEND         = 3'd2,
    PH_WAIT_ACK     = 3'd3,
    PH_SEND_EOT     = 3'd4,
    PH_WAIT_EOT_ACK = 3'd5,
    PH_DONE         = 3'd6,
    PH_FAILED       = 3'd7
  } phase_t;

  localparam logic [7:0] FILL_FULL  = 8'(BLOCK_BYTES);
  localparam logic [7:0] IDX_CRC_HI = 8'(BLOCK_BYTES + HDR_BYTES);
  localparam logic [7:0] IDX_LAST   = 8'(FRAME_LEN - 1);
  localparam logic [7:0] HDR_LEN    = 8'(HDR_BYTES);

  // Sequencer state
  phase_t      phase, phase_next;
  logic [7:0]  fill_count, fill_count_next;
  logic        final_block, final_block_next;
  logic [7:0]  frame_index, frame_index_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  block_counter, block_counter_next;
  logic [7:0]  attempt_counter, attempt_counter_next;
  logic [15:0] wait_ticks, wait_ticks_next;

  // Result register
  logic        out_tx_valid, out_frame_end, out_accepted;
  logic [7:0]  out_byte;
  logic [23:0] out_meta;
  logic        res_tx_valid, res_frame_end, res_accepted;
  logic [7:0]  res_byte;

  // Block buffer
  logic [7:0]        buffer [BLOCK_BYTES];
  logic              buf_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        rd_index;

  logic        waiting;
  logic        do_fail;
  logic [7:0]  att_inc;
  logic [7:0]  data_idx;
  logic [15:0] wt_inc;
  logic [7:0]  fill_inc;

  // Take an item whenever the result register is free or drains this cycle
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // Item processing
  always_comb begin
    phase_next           = phase;
    fill_count_next      = fill_count;
    final_block_next     = final_block;
    frame_index_next     = frame_index;
    crc_next             = crc;
    block_counter_next   = block_counter;
    attempt_counter_next = attempt_counter;
    wait_ticks_next      = wait_ticks;
    res_tx_valid  = 1'b0;
    res_frame_end = 1'b0;
    res_accepted  = 1'b0;
    res_byte      = 8'h00;
    buf_we        = 1'b0;
    do_fail       = 1'b0;
    waiting  = (phase == PH_WAIT_START) || (phase == PH_WAIT_ACK) ||
               (phase == PH_WAIT_EOT_ACK);
    att_inc  = (attempt_counter == 8'hff) ? 8'hff : attempt_counter + 8'd1;
    data_idx = frame_index - HDR_LEN;
    wt_inc   = wait_ticks + 16'd1;
    fill_inc = fill_count + 8'd1;

    if (q_pop) begin
      unique case (q_item.kind)
        KIND_PAYLOAD: begin
          if (phase == PH_FILL && fill_count < FILL_FULL) begin
            buf_we          = 1'b1;
            res_accepted    = 1'b1;
            fill_count_next = fill_inc;
            if (q_item.last || fill_inc >= FILL_FULL) begin
              final_block_next = q_item.last;
              frame_index_next = 8'd0;
              phase_next       = PH_SEND;
            end
          end
        end
        KIND_RX: begin
          if (waiting) begin
            wait_ticks_next = 16'd0;
            if (phase == PH_WAIT_START) begin
              if (q_item.data == BYTE_START) begin
                phase_next           = PH_FILL;
                attempt_counter_next = 8'd0;
                fill_count_next      = 8'd0;
              end else begin
                do_fail = 1'b1;
              end
            end else if (q_item.data == BYTE_ACK) begin
              attempt_counter_next = 8'd0;
              if (phase == PH_WAIT_EOT_ACK) begin
                phase_next = PH_DONE;
              end else if (final_block) begin
                phase_next = PH_SEND_EOT;
              end else begin
                block_counter_next = block_counter + 8'd1;
                fill_count_next    = 8'd0;
                phase_next         = PH_FILL;
              end
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        KIND_SLOT: begin
          if (phase == PH_SEND) begin
            res_tx_valid = 1'b1;
            // Header, data with zero padding, then CRC; CRC runs over the data bytes as they go out, padding included
            if (frame_index == 8'd0) begin
              res_byte = BYTE_SOH;
              crc_next = 16'h0000;
            end else if (frame_index == 8'd1) begin
              res_byte = block_counter;
            end else if (frame_index == 8'd2) begin
              res_byte = ~block_counter;
            end else if (frame_index < IDX_CRC_HI) begin
              res_byte = (data_idx < fill_count) ? rd_data : 8'h00;
              crc_next = crc_step(crc, res_byte);
            end else if (frame_index == IDX_CRC_HI) begin
              res_byte = crc[15:8];
            end else begin
              res_byte = crc[7:0];
            end
            if (frame_index >= IDX_LAST) begin
              res_frame_end    = 1'b1;
              frame_index_next = 8'd0;
              wait_ticks_next  = 16'd0;
              phase_next       = PH_WAIT_ACK;
            end else begin
              frame_index_next = frame_index + 8'd1;
            end
          end else if (phase == PH_SEND_EOT) begin
            res_tx_valid    = 1'b1;
            res_byte        = BYTE_EOT;
            res_frame_end   = 1'b1;
            wait_ticks_next = 16'd0;
            phase_next      = PH_WAIT_EOT_ACK;
          end
        end
        KIND_TICK: begin
          if (waiting) begin
            wait_ticks_next = wt_inc;
            if (wt_inc >= timeout_ticks) begin
              do_fail = 1'b1;
            end
          end
        end
        KIND_RESTART: begin
          phase_next           = PH_WAIT_START;
          fill_count_next      = 8'd0;
          final_block_next     = 1'b0;
          frame_index_next     = 8'd0;
          crc_next             = 16'h0000;
          block_counter_next   = 8'd1;
          attempt_counter_next = 8'd0;
          wait_ticks_next      = 16'd0;
        end
        default: begin
        end
      endcase
    end

    // One failed attempt: count it, then fail or retry
    if (do_fail) begin
      wait_ticks_next      = 16'd0;
      attempt_counter_next = att_inc;
      if (att_inc >= max_attempts) begin
        phase_next = PH_FAILED;
      end else if (phase == PH_WAIT_ACK) begin
        phase_next       = PH_SEND;
        frame_index_next = 8'd0;
      end else if (phase == PH_WAIT_EOT_ACK) begin
        phase_next = PH_SEND_EOT;
      end
    end

    // Prefetch the data byte for the frame position after this item
    rd_index = frame_index_next - HDR_LEN;
    rd_addr  = rd_index[ADDR_W-1:0];
  end

  // Block buffer, registered read
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buffer[fill_count[ADDR_W-1:0]] <= q_item.data;
    end
    rd_data <= buffer[rd_addr];
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT_START;
      fill_count      <= 8'd0;
      final_block     <= 1'b0;
      frame_index     <= 8'd0;
      crc             <= 16'h0000;
      block_counter   <= 8'd1;
      attempt_counter <= 8'd0;
      wait_ticks      <= 16'd0;
      m_tvalid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      fill_count      <= fill_count_next;
      final_block     <= final_block_next;
      frame_index     <= frame_index_next;
      crc             <= crc_next;
      block_counter   <= block_counter_next;
      attempt_counter <= attempt_counter_next;
      wait_ticks      <= wait_ticks_next;
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tx_valid  <= res_tx_valid;
      out_frame_end <= res_frame_end;
      out_accepted  <= res_accepted;
      out_byte      <= res_byte;
      out_meta      <= {4'b0000, block_counter_next, attempt_counter_next,
                        phase_next, res_accepted};
    end
  end

  assign m_tdata = {out_meta, out_byte};
  assign m_tuser = out_tx_valid;
  assign m_tlast = out_frame_end;

  a_frame_idle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_SEND) |-> (frame_index == 8'd0))
    else $error("frame position left over outside block send");
  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILL) |-> (fill_count < FILL_FULL))
    else $error("fill phase with a full block");
  a_end_has_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_frame_end) |-> out_tx_valid)
    else $error("frame end without a transmitted byte");
  a_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res_accepted) |-> (phase == PH_FILL))
    else $error("payload taken outside fill");

endmodule

`default_nettype wire
